FILE: rtl/assert_macros.svh
// assertion macros shared by the sampler rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is high
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check, also during reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/upids_pkg.sv
// package: constants, types and helpers of the uniform point sampler
`default_nettype none

package upids_pkg;

   localparam int DEF_CORDIC_STAGES = 24;
   localparam int FRAC_BITS = 16;
   localparam int GUARD_BITS = 8;
   localparam int ADDR_W = 5;

   localparam int RAD_W = 62;
   localparam int ROOT_W = 31;
   localparam int REM_W = 33;
   localparam int XW = 42;
   localparam int ZW = 32;
   localparam int OFF_W = 34;
   localparam int C_W = XW - GUARD_BITS;
   localparam int O_W = C_W + 1;

   localparam logic [31:0] INV_GAIN = 32'h9B74_EDA8;
   localparam logic [31:0] EXTENT_RESET = 32'(2 ** FRAC_BITS);
   localparam logic signed [XW-1:0] HALF_G = XW'(2 ** (GUARD_BITS - 1));

   localparam logic [2:0] REG_DOMAIN_KIND = 3'd0;
   localparam logic [2:0] REG_ORIGIN_X = 3'd1;
   localparam logic [2:0] REG_ORIGIN_Y = 3'd2;
   localparam logic [2:0] REG_EXTENT_ONE = 3'd3;
   localparam logic [2:0] REG_EXTENT_TWO = 3'd4;

   localparam logic KIND_RECT = 1'b0;
   localparam logic KIND_ANNULUS = 1'b1;

   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   typedef struct packed {
      logic [31:0] u2;
      logic signed [OFF_W-1:0] off_x;
      logic signed [OFF_W-1:0] off_y;
   } sq_side_type;

   typedef struct packed {
      logic [1:0] quad;
      logic signed [OFF_W-1:0] off_x;
      logic signed [OFF_W-1:0] off_y;
   } cd_side_type;

   function automatic logic [ZW-1:0] atan_unit(input int idx);
      logic [ZW-1:0] a;
      case (idx)
         0: a = 32'h2000_0000;
         1: a = 32'h12E4_051E;
         2: a = 32'h09FB_385B;
         3: a = 32'h0511_11D4;
         4: a = 32'h028B_0D43;
         5: a = 32'h0145_D7E1;
         6: a = 32'h00A2_F61E;
         7: a = 32'h0051_7C55;
         8: a = 32'h0028_BE53;
         9: a = 32'h0014_5F2F;
         10: a = 32'h000A_2F98;
         11: a = 32'h0005_17CC;
         12: a = 32'h0002_8BE6;
         13: a = 32'h0001_45F3;
         14: a = 32'h0000_A2FA;
         15: a = 32'h0000_517D;
         16: a = 32'h0000_28BE;
         17: a = 32'h0000_145F;
         18: a = 32'h0000_0A30;
         19: a = 32'h0000_0518;
         20: a = 32'h0000_028C;
         21: a = 32'h0000_0146;
         22: a = 32'h0000_00A3;
         23: a = 32'h0000_0051;
         24: a = 32'h0000_0029;
         25: a = 32'h0000_0014;
         26: a = 32'h0000_000A;
         27: a = 32'h0000_0005;
         28: a = 32'h0000_0003;
         29: a = 32'h0000_0001;
         30: a = 32'h0000_0001;
         default: a = 32'h0000_0000;
      endcase
      return a;
   endfunction

   function automatic logic [31:0] sat32(input logic signed [35:0] v);
      logic [31:0] r;
      if (v > 36'sh0_7FFF_FFFF) begin
         r = 32'h7FFF_FFFF;
      end else if (v < -36'sh0_8000_0000) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/upids_sqrt_cell.sv
// one radix-2 restoring square root cell, one root bit per cycle while adv is high
`default_nettype none
`include "assert_macros.svh"

module upids_sqrt_cell import upids_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              adv,
   input  wire logic              v_in,
   input  wire logic [RAD_W-1:0]  rad_in,
   input  wire logic [REM_W-1:0]  rem_in,
   input  wire logic [ROOT_W-1:0] root_in,
   input  wire sq_side_type       side_in,
   output logic                   v_out,
   output logic [RAD_W-1:0]       rad_out,
   output logic [REM_W-1:0]       rem_out,
   output logic [ROOT_W-1:0]      root_out,
   output sq_side_type            side_out
);

   logic v_ff;
   logic [RAD_W-1:0] rad_ff, rad_in_nx;
   logic [REM_W-1:0] rem_ff, rem_in_nx;
   logic [ROOT_W-1:0] root_ff, root_in_nx;
   sq_side_type side_ff;
   logic [REM_W+1:0] cand, trial, diff;
   logic ge;

   always_comb begin
      cand = {rem_in, rad_in[RAD_W-1 -: 2]};
      trial = {{(REM_W-ROOT_W){1'b0}}, root_in, 2'b01};
      diff = cand - trial;
      ge = (cand >= trial);
      rem_in_nx = ge ? diff[REM_W-1:0] : cand[REM_W-1:0];
      root_in_nx = {root_in[ROOT_W-2:0], ge};
      rad_in_nx = {rad_in[RAD_W-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (adv) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rad_ff <= rad_in_nx;
         rem_ff <= rem_in_nx;
         root_ff <= root_in_nx;
         side_ff <= side_in;
      end
   end

   assign v_out = v_ff;
   assign rad_out = rad_ff;
   assign rem_out = rem_ff;
   assign root_out = root_ff;
   assign side_out = side_ff;

   // partial remainder never exceeds twice the partial root
   `ASSERT_CLK(a_rem_bound, clock, reset, v_ff |-> (rem_ff <= {root_ff, 1'b0}), "sqrt remainder out of range")

endmodule

`default_nettype wire

FILE: rtl/upids_cordic_cell.sv
// one cordic rotation cell with a fixed shift and arctangent
`default_nettype none

module upids_cordic_cell import upids_pkg::*; #(
   parameter int STAGE = 0
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 adv,
   input  wire logic                 v_in,
   input  wire logic signed [XW-1:0] x_in,
   input  wire logic signed [XW-1:0] y_in,
   input  wire logic signed [ZW-1:0] z_in,
   input  wire cd_side_type          side_in,
   output logic                      v_out,
   output logic signed [XW-1:0]      x_out,
   output logic signed [XW-1:0]      y_out,
   output logic signed [ZW-1:0]      z_out,
   output cd_side_type               side_out
);

   localparam logic signed [ZW-1:0] ANGLE = signed'(atan_unit(STAGE));

   logic v_ff;
   logic signed [XW-1:0] x_ff, y_ff, x_nx, y_nx, dx, dy;
   logic signed [ZW-1:0] z_ff, z_nx;
   cd_side_type side_ff;

   always_comb begin
      dx = y_in >>> STAGE;
      dy = x_in >>> STAGE;
      if (!z_in[ZW-1]) begin
         x_nx = x_in - dx;
         y_nx = y_in + dy;
         z_nx = z_in - ANGLE;
      end else begin
         x_nx = x_in + dx;
         y_nx = y_in - dy;
         z_nx = z_in + ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (adv) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff <= x_nx;
         y_ff <= y_nx;
         z_ff <= z_nx;
         side_ff <= side_in;
      end
   end

   assign v_out = v_ff;
   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;
   assign side_out = side_ff;

endmodule

`default_nettype wire

FILE: rtl/uniform_point_in_domain_sampler_unit.sv
// top level: uniform point sampler over a rectangle or an annulus
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_uniform_one, req_uniform_two
//   rsp      out        rsp_valid/rsp_stall   rsp_point_x, rsp_point_y
//   csr      in         psel/penable/pready   paddr, pwdata, prdata
//
// one word per cycle while req_stall is low; each word passes the front stages, the
// 31-cell square root chain, the gain stages and the cordic cell chain, which all move
// together with the last stage; an empty last stage lets them close up under stall
// req_stall is high only while a finished word waits and the last stage is full
// synchronous reset clears valid bits and loads register defaults
`default_nettype none
`include "assert_macros.svh"

module uniform_point_in_domain_sampler_unit import upids_pkg::*; #(
   parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [31:0]       req_uniform_one,
   input  wire logic [31:0]       req_uniform_two,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic signed [31:0]     rsp_point_x,
   output logic signed [31:0]     rsp_point_y,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [31:0]       pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);

   // configuration registers
   logic kind_ff, kind_in;
   logic [31:0] origin_x_ff, origin_x_in, origin_y_ff, origin_y_in;
   logic [31:0] extent_one_ff, extent_one_in, extent_two_ff, extent_two_in;
   logic cfg_wr;
   logic [2:0] cfg_idx;

   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;
   assign cfg_idx = paddr[4:2];

   always_comb begin
      kind_in = kind_ff;
      origin_x_in = origin_x_ff;
      origin_y_in = origin_y_ff;
      extent_one_in = extent_one_ff;
      extent_two_in = extent_two_ff;
      if (cfg_wr) begin
         case (cfg_idx)
            REG_DOMAIN_KIND: kind_in = pwdata[0];
            REG_ORIGIN_X: origin_x_in = pwdata;
            REG_ORIGIN_Y: origin_y_in = pwdata;
            REG_EXTENT_ONE: extent_one_in = pwdata;
            REG_EXTENT_TWO: extent_two_in = pwdata;
            default: kind_in = kind_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= KIND_RECT;
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         extent_one_ff <= EXTENT_RESET;
         extent_two_ff <= EXTENT_RESET;
      end else begin
         kind_ff <= kind_in;
         origin_x_ff <= origin_x_in;
         origin_y_ff <= origin_y_in;
         extent_one_ff <= extent_one_in;
         extent_two_ff <= extent_two_in;
      end
   end

   always_comb begin
      case (cfg_idx)
         REG_DOMAIN_KIND: prdata = {31'd0, kind_ff};
         REG_ORIGIN_X: prdata = origin_x_ff;
         REG_ORIGIN_Y: prdata = origin_y_ff;
         REG_EXTENT_ONE: prdata = extent_one_ff;
         REG_EXTENT_TWO: prdata = extent_two_ff;
         default: prdata = '0;
      endcase
   end

   // flow control
   logic adv, out_load, i_v_ff, rsp_valid_ff;

   assign out_load = !rsp_valid_ff || !rsp_stall;
   assign adv = out_load || !i_v_ff;
   assign req_stall = !adv;

   // front stages: radius squared and rectangle offsets
   logic a_v_ff, b_v_ff, c_v_ff, d_v_ff, e_v_ff, f_v_ff;
   logic [31:0] a_u1_ff, a_u2_ff, b_u1_ff, b_u2_ff, c_u1_ff, c_u2_ff, d_u2_ff, e_u2_ff;
   logic [30:0] inner, outer;
   logic signed [32:0] span_x, span_y;
   logic [RAD_W-1:0] b_i2_ff, b_i2_in, b_o2_ff, b_o2_in;
   logic [32:0] b_magx_ff, b_magx_in, b_magy_ff, b_magy_in;
   logic b_negx_ff, b_negy_ff, c_negx_ff, c_negy_ff, d_negx_ff, d_negy_ff;
   logic [RAD_W-1:0] c_d_ff, c_d_in, c_base_ff, d_base_ff, e_base_ff;
   logic c_dneg_ff, d_dneg_ff, e_dneg_ff;
   logic [64:0] c_px_ff, c_px_in, c_py_ff, c_py_in;
   logic [RAD_W-1:0] d_ph_ff, d_ph_in;
   logic [63:0] d_pl_ff, d_pl_in;
   logic [65:0] sum_px, sum_py;
   logic [32:0] d_tx_ff, d_ty_ff;
   logic [RAD_W-1:0] e_p_ff, e_p_in, f_s_ff, f_s_in;
   logic signed [OFF_W-1:0] e_offx_ff, e_offx_in, e_offy_ff, e_offy_in;
   sq_side_type f_side_ff;

   always_comb begin
      inner = extent_one_ff[31] ? 31'd0 : extent_one_ff[30:0];
      outer = extent_two_ff[31] ? 31'd0 : extent_two_ff[30:0];
      b_i2_in = RAD_W'(inner) * RAD_W'(inner);
      b_o2_in = RAD_W'(outer) * RAD_W'(outer);
      span_x = signed'({extent_one_ff[31], extent_one_ff}) -
               signed'({origin_x_ff[31], origin_x_ff});
      span_y = signed'({extent_two_ff[31], extent_two_ff}) -
               signed'({origin_y_ff[31], origin_y_ff});
      b_magx_in = span_x[32] ? 33'(-span_x) : 33'(span_x);
      b_magy_in = span_y[32] ? 33'(-span_y) : 33'(span_y);
      c_d_in = (b_i2_ff > b_o2_ff) ? b_i2_ff - b_o2_ff : b_o2_ff - b_i2_ff;
      c_px_in = 65'(b_magx_ff) * 65'(b_u1_ff);
      c_py_in = 65'(b_magy_ff) * 65'(b_u2_ff);
      d_ph_in = RAD_W'(c_d_ff[RAD_W-1:32]) * RAD_W'(c_u1_ff);
      d_pl_in = 64'(c_d_ff[31:0]) * 64'(c_u1_ff);
      sum_px = 66'(c_px_ff) + 66'h0_8000_0000;
      sum_py = 66'(c_py_ff) + 66'h0_8000_0000;
      e_p_in = d_ph_ff + RAD_W'(d_pl_ff[63:32]);
      e_offx_in = d_negx_ff ? OFF_W'(0) - signed'({1'b0, d_tx_ff}) : signed'({1'b0, d_tx_ff});
      e_offy_in = d_negy_ff ? OFF_W'(0) - signed'({1'b0, d_ty_ff}) : signed'({1'b0, d_ty_ff});
      f_s_in = e_dneg_ff ? e_base_ff - e_p_ff : e_base_ff + e_p_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
         d_v_ff <= 1'b0;
         e_v_ff <= 1'b0;
         f_v_ff <= 1'b0;
      end else if (adv) begin
         a_v_ff <= req_valid;
         b_v_ff <= a_v_ff;
         c_v_ff <= b_v_ff;
         d_v_ff <= c_v_ff;
         e_v_ff <= d_v_ff;
         f_v_ff <= e_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_u1_ff <= req_uniform_one;
         a_u2_ff <= req_uniform_two;
         b_u1_ff <= a_u1_ff;
         b_u2_ff <= a_u2_ff;
         b_i2_ff <= b_i2_in;
         b_o2_ff <= b_o2_in;
         b_magx_ff <= b_magx_in;
         b_magy_ff <= b_magy_in;
         b_negx_ff <= span_x[32];
         b_negy_ff <= span_y[32];
         c_u1_ff <= b_u1_ff;
         c_u2_ff <= b_u2_ff;
         c_d_ff <= c_d_in;
         c_dneg_ff <= (b_i2_ff > b_o2_ff);
         c_base_ff <= b_i2_ff;
         c_px_ff <= c_px_in;
         c_py_ff <= c_py_in;
         c_negx_ff <= b_negx_ff;
         c_negy_ff <= b_negy_ff;
         d_u2_ff <= c_u2_ff;
         d_ph_ff <= d_ph_in;
         d_pl_ff <= d_pl_in;
         d_base_ff <= c_base_ff;
         d_dneg_ff <= c_dneg_ff;
         d_tx_ff <= sum_px[64:32];
         d_ty_ff <= sum_py[64:32];
         d_negx_ff <= c_negx_ff;
         d_negy_ff <= c_negy_ff;
         e_u2_ff <= d_u2_ff;
         e_p_ff <= e_p_in;
         e_base_ff <= d_base_ff;
         e_dneg_ff <= d_dneg_ff;
         e_offx_ff <= e_offx_in;
         e_offy_ff <= e_offy_in;
         f_s_ff <= f_s_in;
         f_side_ff.u2 <= e_u2_ff;
         f_side_ff.off_x <= e_offx_ff;
         f_side_ff.off_y <= e_offy_ff;
      end
   end

   // square root chain
   logic sq_v [0:ROOT_W];
   logic [RAD_W-1:0] sq_rad [0:ROOT_W];
   logic [REM_W-1:0] sq_rem [0:ROOT_W];
   logic [ROOT_W-1:0] sq_root [0:ROOT_W];
   sq_side_type sq_side [0:ROOT_W];

   assign sq_v[0] = f_v_ff;
   assign sq_rad[0] = f_s_ff;
   assign sq_rem[0] = '0;
   assign sq_root[0] = '0;
   assign sq_side[0] = f_side_ff;

   for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
      upids_sqrt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .v_in     (sq_v[k]),
         .rad_in   (sq_rad[k]),
         .rem_in   (sq_rem[k]),
         .root_in  (sq_root[k]),
         .side_in  (sq_side[k]),
         .v_out    (sq_v[k+1]),
         .rad_out  (sq_rad[k+1]),
         .rem_out  (sq_rem[k+1]),
         .root_out (sq_root[k+1]),
         .side_out (sq_side[k+1])
      );
   end

   // gain correction and start vector
   logic g_v_ff, h_v_ff;
   logic [62:0] g_prod_ff, g_prod_in;
   logic [29:0] g_z_ff;
   cd_side_type g_side_ff, h_side_ff;
   logic [63:0] h_sum;
   logic signed [XW-1:0] h_x_ff, h_x_in;
   logic signed [ZW-1:0] h_z_ff;

   always_comb begin
      g_prod_in = 63'(sq_root[ROOT_W]) * 63'(INV_GAIN);
      h_sum = 64'(g_prod_ff) + 64'h0000_0000_8000_0000;
      h_x_in = signed'(XW'({h_sum[63:32], {GUARD_BITS{1'b0}}}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g_v_ff <= 1'b0;
         h_v_ff <= 1'b0;
      end else if (adv) begin
         g_v_ff <= sq_v[ROOT_W];
         h_v_ff <= g_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         g_prod_ff <= g_prod_in;
         g_z_ff <= sq_side[ROOT_W].u2[29:0];
         g_side_ff.quad <= sq_side[ROOT_W].u2[31:30];
         g_side_ff.off_x <= sq_side[ROOT_W].off_x;
         g_side_ff.off_y <= sq_side[ROOT_W].off_y;
         h_x_ff <= h_x_in;
         h_z_ff <= signed'({2'b00, g_z_ff});
         h_side_ff <= g_side_ff;
      end
   end

   // cordic chain
   logic cd_v [0:CORDIC_STAGES];
   logic signed [XW-1:0] cd_x [0:CORDIC_STAGES];
   logic signed [XW-1:0] cd_y [0:CORDIC_STAGES];
   logic signed [ZW-1:0] cd_z [0:CORDIC_STAGES];
   cd_side_type cd_side [0:CORDIC_STAGES];

   assign cd_v[0] = h_v_ff;
   assign cd_x[0] = h_x_ff;
   assign cd_y[0] = '0;
   assign cd_z[0] = h_z_ff;
   assign cd_side[0] = h_side_ff;

   for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
      upids_cordic_cell #(.STAGE(k)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .v_in     (cd_v[k]),
         .x_in     (cd_x[k]),
         .y_in     (cd_y[k]),
         .z_in     (cd_z[k]),
         .side_in  (cd_side[k]),
         .v_out    (cd_v[k+1]),
         .x_out    (cd_x[k+1]),
         .y_out    (cd_y[k+1]),
         .z_out    (cd_z[k+1]),
         .side_out (cd_side[k+1])
      );
   end

   // rounding, quadrant mapping and domain select
   logic signed [XW-1:0] xr, yr, xs, ys;
   logic signed [O_W-1:0] ce, se, nce, nse, qx, qy;
   logic signed [O_W-1:0] i_ox_ff, i_ox_in, i_oy_ff, i_oy_in;
   cd_side_type last_side;

   always_comb begin
      last_side = cd_side[CORDIC_STAGES];
      xr = cd_x[CORDIC_STAGES] + HALF_G;
      yr = cd_y[CORDIC_STAGES] + HALF_G;
      xs = xr >>> GUARD_BITS;
      ys = yr >>> GUARD_BITS;
      ce = signed'({xs[C_W-1], xs[C_W-1:0]});
      se = signed'({ys[C_W-1], ys[C_W-1:0]});
      nce = O_W'(0) - ce;
      nse = O_W'(0) - se;
      case (last_side.quad)
         QUAD_0: begin
            qx = ce;
            qy = se;
         end
         QUAD_1: begin
            qx = nse;
            qy = ce;
         end
         QUAD_2: begin
            qx = nce;
            qy = nse;
         end
         default: begin
            qx = se;
            qy = nce;
         end
      endcase
      if (kind_ff == KIND_ANNULUS) begin
         i_ox_in = qx;
         i_oy_in = qy;
      end else begin
         i_ox_in = signed'({last_side.off_x[OFF_W-1], last_side.off_x});
         i_oy_in = signed'({last_side.off_y[OFF_W-1], last_side.off_y});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         i_v_ff <= 1'b0;
      end else if (adv) begin
         i_v_ff <= cd_v[CORDIC_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         i_ox_ff <= i_ox_in;
         i_oy_ff <= i_oy_in;
      end
   end

   // output register: add origin and saturate
   logic signed [35:0] sum_x, sum_y;
   logic [31:0] rsp_x_ff, rsp_y_ff;

   always_comb begin
      sum_x = signed'({{4{origin_x_ff[31]}}, origin_x_ff}) +
              signed'({i_ox_ff[O_W-1], i_ox_ff});
      sum_y = signed'({{4{origin_y_ff[31]}}, origin_y_ff}) +
              signed'({i_oy_ff[O_W-1], i_oy_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= i_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_x_ff <= sat32(sum_x);
         rsp_y_ff <= sat32(sum_y);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_point_x = signed'(rsp_x_ff);
   assign rsp_point_y = signed'(rsp_y_ff);

   // a finished word in the last stage reaches the output once it is free
   `ASSERT_CLK(a_last_moves, clock, reset, (i_v_ff && out_load) |=> rsp_valid_ff, "last stage word lost")
   // input stalls only behind a real word in the last stage
   `ASSERT_CLK(a_stall_real, clock, reset, req_stall |-> (i_v_ff && rsp_valid_ff), "stall without a blocked word")

endmodule

`default_nettype wire

FILE: dv/tb.sv
// testbench: uniform point sampler, checked against an in-bench predictor
`timescale 1ns / 100ps
`default_nettype none

module tb;
   import upids_pkg::*;

   localparam int STAGES = DEF_CORDIC_STAGES;
   localparam int LATENCY = 40 + STAGES;
   localparam logic [31:0] INV_GAIN_Q32 = 32'h9B74_EDA8;

   typedef struct {
      logic signed [31:0] px;
      logic signed [31:0] py;
   } point_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [31:0] req_uniform_one = '0;
   logic [31:0] req_uniform_two = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_point_x;
   logic signed [31:0] rsp_point_y;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   logic kind_q;
   logic signed [31:0] org_x_q, org_y_q, ext_one_q, ext_two_q;

   point_t expected_points[$];
   int n_fail = 0;
   int rsp_hold = 0;
   bit stall_enable = 1'b1;

   uniform_point_in_domain_sampler_unit #(.CORDIC_STAGES(STAGES)) i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_uniform_one(req_uniform_one), .req_uniform_two(req_uniform_two),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_point_x(rsp_point_x), .rsp_point_y(rsp_point_y),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [31:0] saturate(input longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   function automatic longint floor_shift(input longint v, input int s);
      return v >>> s;
   endfunction

   function automatic longint rect_coord(input longint lo, input longint hi,
                                         input logic [31:0] u);
      longint span;
      logic [63:0] mag, t;
      span = hi - lo;
      mag = span < 0 ? -span : span;
      t = (mag * {32'd0, u} + 64'h8000_0000) >> 32;
      return span < 0 ? lo - longint'(t) : lo + longint'(t);
   endfunction

   function automatic logic [63:0] int_sqrt(input logic [63:0] s);
      logic [63:0] rem, root, b;
      rem = s;
      root = 0;
      b = 64'd1 << 62;
      while (b > rem) b = b >> 2;
      while (b != 0) begin
         if (rem >= root + b) begin
            rem = rem - (root + b);
            root = (root >> 1) + b;
         end else begin
            root = root >> 1;
         end
         b = b >> 2;
      end
      return root;
   endfunction

   function automatic logic [63:0] frac_scale(input logic [63:0] m, input logic [31:0] u);
      return (m >> 32) * u + (((m & 64'hFFFF_FFFF) * u) >> 32);
   endfunction

   function automatic point_t predict_point(input logic [31:0] u1, input logic [31:0] u2);
      point_t p;
      logic [63:0] inner, outer, i2, o2, s, r;
      longint x, y, z, dx, dy, c, sn, ox, oy;
      if (kind_q == KIND_RECT) begin
         p.px = saturate(rect_coord(org_x_q, ext_one_q, u1));
         p.py = saturate(rect_coord(org_y_q, ext_two_q, u2));
         return p;
      end
      inner = ext_one_q < 0 ? 0 : ext_one_q;
      outer = ext_two_q < 0 ? 0 : ext_two_q;
      i2 = inner * inner;
      o2 = outer * outer;
      s = (o2 >= i2) ? i2 + frac_scale(o2 - i2, u1) : i2 - frac_scale(i2 - o2, u1);
      r = int_sqrt(s);
      x = longint'((r * INV_GAIN_Q32 + 64'h8000_0000) >> 32) << GUARD_BITS;
      y = 0;
      z = u2[29:0];
      for (int i = 0; i < (STAGES > 32 ? 32 : STAGES); i++) begin
         dx = floor_shift(y, i);
         dy = floor_shift(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(atan_unit(i));
         end else begin
            x += dx; y -= dy; z += longint'(atan_unit(i));
         end
      end
      c = floor_shift(x + (1 << (GUARD_BITS - 1)), GUARD_BITS);
      sn = floor_shift(y + (1 << (GUARD_BITS - 1)), GUARD_BITS);
      case (u2[31:30])
         QUAD_0: begin ox = c; oy = sn; end
         QUAD_1: begin ox = -sn; oy = c; end
         QUAD_2: begin ox = -c; oy = -sn; end
         default: begin ox = sn; oy = -c; end
      endcase
      p.px = saturate(longint'(org_x_q) + ox);
      p.py = saturate(longint'(org_y_q) + oy);
      return p;
   endfunction

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= ADDR_W'({idx, 2'b00}); pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (idx)
         REG_DOMAIN_KIND: kind_q = val[0];
         REG_ORIGIN_X: org_x_q = val;
         REG_ORIGIN_Y: org_y_q = val;
         REG_EXTENT_ONE: ext_one_q = val;
         REG_EXTENT_TWO: ext_two_q = val;
         default: ;
      endcase
   endtask

   task automatic set_domain(input logic k, input logic [31:0] ox, input logic [31:0] oy,
                             input logic [31:0] e1, input logic [31:0] e2);
      while (expected_points.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      write_reg(REG_DOMAIN_KIND, {31'd0, k});
      write_reg(REG_ORIGIN_X, ox);
      write_reg(REG_ORIGIN_Y, oy);
      write_reg(REG_EXTENT_ONE, e1);
      write_reg(REG_EXTENT_TWO, e2);
   endtask

   task automatic send_word(input logic [31:0] u1, input logic [31:0] u2, input bit gaps);
      int gap;
      gap = gaps ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_uniform_one <= u1;
      req_uniform_two <= u2;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_points.push_back(predict_point(u1, u2));
   endtask

   task automatic idle_req();
      req_valid <= 1'b0;
   endtask

   function automatic logic [31:0] edge_frac();
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         3: return {2'($urandom_range(0, 3)), 30'd0};
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return $urandom;
         default: return 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
      endcase
   endfunction

   task automatic test_reset_defaults();
      send_word(32'd0, 32'd0, 1'b0);
      send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      send_word(32'h8000_0000, 32'h4000_0000, 1'b0);
      idle_req();
   endtask

   task automatic test_rect_extremes();
      set_domain(KIND_RECT, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
      send_word(32'd0, 32'd0, 1'b0);
      send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      send_word(32'h8000_0000, 32'h5555_5555, 1'b0);
      idle_req();
      set_domain(KIND_RECT, 32'h7FFF_0000, 32'h8000_0000, 32'h8001_0000, 32'h7FFF_FFFF);
      send_word(32'hFFFF_FFFF, 32'd1, 1'b0);
      send_word(32'h8000_0000, 32'h8000_0000, 1'b0);
      idle_req();
   endtask

   task automatic test_annulus_cases();
      // regular, inverted and negative radii
      set_domain(KIND_ANNULUS, 32'd0, 32'd0, 32'h0001_0000, 32'h0004_0000);
      for (int q = 0; q < 4; q++) send_word(32'h8000_0000, {q[1:0], 30'd0}, 1'b0);
      send_word(32'd0, 32'h1FFF_FFFF, 1'b0);
      send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      idle_req();
      set_domain(KIND_ANNULUS, 32'h7FFF_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      send_word(32'd0, 32'd0, 1'b0);
      send_word(32'hFFFF_FFFF, 32'hC000_0000, 1'b0);
      send_word(32'h4000_0000, 32'h4000_0000, 1'b0);
      idle_req();
      set_domain(KIND_ANNULUS, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      send_word(32'hFFFF_FFFF, 32'hBFFF_FFFF, 1'b0);
      send_word(32'h1234_5678, 32'h3FFF_FFFF, 1'b0);
      idle_req();
   endtask

   task automatic test_random_stream();
      for (int ph = 0; ph < 18; ph++) begin
         set_domain(1'($urandom_range(0, 1)), rand_coord(), rand_coord(), rand_coord(),
                    rand_coord());
         stall_enable = ph % 3 != 2;
         for (int n = 0; n < 100; n++)
            send_word(edge_frac(), edge_frac(), ph % 3 != 1);
         idle_req();
      end
      stall_enable = 1'b1;
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_points.size() == 0) begin
               $error("unexpected word x=%0d y=%0d", rsp_point_x, rsp_point_y);
               n_fail++;
            end else begin
               point_t e;
               e = expected_points.pop_front();
               if (rsp_point_x !== e.px) begin
                  $error("point_x expected %0d actual %0d", e.px, rsp_point_x);
                  n_fail++;
               end
               if (rsp_point_y !== e.py) begin
                  $error("point_y expected %0d actual %0d", e.py, rsp_point_y);
                  n_fail++;
               end
            end
            // wait drawn once per word
            rsp_hold = stall_enable ? $urandom_range(0, 3) : 0;
         end
         if (rsp_hold > 0) begin
            rsp_stall <= 1'b1;
            rsp_hold--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      kind_q = KIND_RECT;
      org_x_q = 0;
      org_y_q = 0;
      ext_one_q = EXTENT_RESET;
      ext_two_q = EXTENT_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_rect_extremes();
      test_annulus_cases();
      test_random_stream();
      while (expected_points.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (n_fail == 0 && expected_points.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

`default_nettype wire
